>>> rtl/q2e_pkg.sv
package q2e_pkg;

  // Field and datapath widths
  localparam int IN_W    = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 34;
  localparam int S_W     = 30;
  localparam int RAD_W   = 57;
  localparam int ROOT_W  = 29;
  localparam int CX_W    = 36;
  localparam int ACC_W   = 26;
  localparam int ANG_W   = 16;
  localparam int PITCH_W = 15;

  // Defaults for the top-level parameters
  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 7;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic signed [SUM_W-1:0] ONE_Q28   = SUM_W'(64'sd268435456);
  localparam logic signed [ACC_W-1:0] DEG90_Q16 = ACC_W'(64'sd5898240);

  // Item passed from the front pipeline to the CORDIC lanes
  typedef struct packed {
    logic signed [SUM_W-1:0] rn;
    logic signed [SUM_W-1:0] rd;
    logic signed [SUM_W-1:0] yn;
    logic signed [SUM_W-1:0] yd;
    logic signed [S_W-1:0]   s;
    logic [ROOT_W-1:0]       c;
  } q2e_vec_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ACC_W-1:0] atan_q16(input int idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/q2e_front.sv
module q2e_front import q2e_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [IN_W-1:0] qw,
  input  logic signed [IN_W-1:0] qx,
  input  logic signed [IN_W-1:0] qy,
  input  logic signed [IN_W-1:0] qz,
  output logic                  out_valid,
  input  logic                  out_ready,
  output q2e_vec_t              out_data
);

  localparam int T_W = RAD_W + 3;
  localparam logic [RAD_W-1:0] ONE_Q56 = RAD_W'(1) << 56;

  logic en;
  logic v1, v2;
  logic signed [PROD_W-1:0] pwx, pyz, pxx, pyy, pwz, pxy, pzz, pwy, pzx;
  q2e_vec_t vec2;
  logic signed [SUM_W-1:0] s_raw;
  logic signed [S_W-1:0]   s_sat;
  logic signed [2*S_W-1:0] s_sq;

  logic                    vld  [0:ROOT_W];
  logic [T_W-1:0]          rem  [0:ROOT_W];
  logic [ROOT_W-1:0]       root [0:ROOT_W];
  q2e_vec_t                vec  [0:ROOT_W];

  // Advance the whole pipe unless the last word is blocked
  assign en       = !vld[ROOT_W] || out_ready;
  assign in_ready = en;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      vld[0] <= v2;
    end
  end

  // Products in Q.28
  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= qw * qx;
      pyz <= qy * qz;
      pxx <= qx * qx;
      pyy <= qy * qy;
      pwz <= qw * qz;
      pxy <= qx * qy;
      pzz <= qz * qz;
      pwy <= qw * qy;
      pzx <= qz * qx;
    end
  end

  // Saturate the arcsine argument to +-1
  always_comb begin
    s_raw = (SUM_W'(pwy) - SUM_W'(pzx)) <<< 1;
    if (s_raw > ONE_Q28)       s_sat = S_W'(ONE_Q28);
    else if (s_raw < -ONE_Q28) s_sat = S_W'(-ONE_Q28);
    else                       s_sat = S_W'(s_raw);
  end

  // Product sums
  always_ff @(posedge clk) begin
    if (en) begin
      vec2.rn <= (SUM_W'(pwx) + SUM_W'(pyz)) <<< 1;
      vec2.rd <= ONE_Q28 - ((SUM_W'(pxx) + SUM_W'(pyy)) <<< 1);
      vec2.yn <= (SUM_W'(pwz) + SUM_W'(pxy)) <<< 1;
      vec2.yd <= ONE_Q28 - ((SUM_W'(pyy) + SUM_W'(pzz)) <<< 1);
      vec2.s  <= s_sat;
      vec2.c  <= '0;
    end
  end

  // Radicand 1 - s^2 in Q.56
  assign s_sq = vec2.s * vec2.s;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= T_W'(ONE_Q56 - RAD_W'(unsigned'(s_sq)));
      root[0] <= '0;
      vec[0]  <= vec2;
    end
  end

  // Square root, one result bit per stage from the top
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [T_W-1:0] trial;
    assign trial = (T_W'(root[j]) << (K + 1)) | (T_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec[j+1] <= vec[j];
        if (rem[j] >= trial) begin
          rem[j+1]  <= rem[j] - trial;
          root[j+1] <= root[j] | (ROOT_W'(1) << K);
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j];
        end
      end
    end
  end

  always_comb begin
    out_data   = vec[ROOT_W];
    out_data.c = root[ROOT_W];
  end
  assign out_valid = vld[ROOT_W];

endmodule

>>> rtl/q2e_queue.sv
module q2e_queue import q2e_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  q2e_vec_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output q2e_vec_t out_data
);

  localparam int AW = $clog2(DEPTH);

  q2e_vec_t      mem [0:DEPTH-1];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          wr_en, rd_en;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;
  assign out_data  = mem[rptr];

  // Store words
  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= in_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + 1'b1;
      if (rd_en) rptr <= rptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count over depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count[AW-1:0] == AW'(wptr - rptr))) else $error("queue pointers disagree with count");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> count == '0) else $error("queue not empty after reset");

endmodule

>>> rtl/q2e_cordic.sv
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS     = DEF_CORDIC_STEPS,
  parameter int FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int LIMIT     = 180
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CX_W-1:0]  y_in,
  input  logic signed [CX_W-1:0]  x_in,
  output logic signed [ANG_W-1:0] angle
);

  localparam int SH = 16 - FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(LIMIT) <<< FRAC_BITS;

  logic signed [CX_W-1:0]  xs  [0:STEPS];
  logic signed [CX_W-1:0]  ys  [0:STEPS];
  logic signed [ACC_W-1:0] acc [0:STEPS];
  logic                    zr  [0:STEPS];

  logic [ACC_W-1:0]        mag;
  logic signed [ACC_W-1:0] rnd, sgn;

  // Turn the vector into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          acc[0] <= DEG90_Q16;
          xs[0]  <= y_in;
          ys[0]  <= -x_in;
        end else begin
          acc[0] <= -DEG90_Q16;
          xs[0]  <= -y_in;
          ys[0]  <= x_in;
        end
      end else begin
        acc[0] <= '0;
        xs[0]  <= x_in;
        ys[0]  <= y_in;
      end
    end
  end

  // One vectoring micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (ys[i] >= 0) begin
          xs[i+1]  <= xs[i] + (ys[i] >>> i);
          ys[i+1]  <= ys[i] - (xs[i] >>> i);
          acc[i+1] <= acc[i] + atan_q16(i);
        end else begin
          xs[i+1]  <= xs[i] - (ys[i] >>> i);
          ys[i+1]  <= ys[i] + (xs[i] >>> i);
          acc[i+1] <= acc[i] - atan_q16(i);
        end
      end
    end
  end

  // Round half away from zero, then clamp
  always_comb begin
    mag = acc[STEPS] < 0 ? unsigned'(-acc[STEPS]) : unsigned'(acc[STEPS]);
    rnd = signed'((mag + HALF) >> SH);
    sgn = acc[STEPS] < 0 ? -rnd : rnd;
    if (sgn > LIM)       sgn = LIM;
    else if (sgn < -LIM) sgn = -LIM;
  end

  always_ff @(posedge clk) begin
    if (en) angle <= zr[STEPS] ? '0 : ANG_W'(sgn);
  end

endmodule

>>> rtl/q2e_back.sv
module q2e_back import q2e_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  q2e_vec_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] roll,
  output logic signed [ANG_W-1:0] pitch,
  output logic signed [ANG_W-1:0] yaw
);

  localparam int LAT = CORDIC_STEPS + 2;

  logic en;
  logic vld [0:LAT-1];

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  // Valid chain matching the lane latency
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  for (genvar i = 1; i < LAT; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (en) vld[i] <= vld[i-1];
    end
  end

  q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(180)) u_roll (
    .clk(clk), .en(en),
    .y_in(CX_W'(in_data.rn)), .x_in(CX_W'(in_data.rd)), .angle(roll)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(90)) u_pitch (
    .clk(clk), .en(en),
    .y_in(CX_W'(in_data.s)), .x_in(CX_W'({1'b0, in_data.c})), .angle(pitch)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT(180)) u_yaw (
    .clk(clk), .en(en),
    .y_in(CX_W'(in_data.yn)), .x_in(CX_W'(in_data.yd)), .angle(yaw)
  );

endmodule

>>> rtl/quaternion_to_euler_angles.sv
// Quaternion to roll/pitch/yaw converter.
// Input stream s_axis: one quaternion per word, four signed Q2.14 components
// (16384 = 1.0). Output stream m_axis: roll, pitch and yaw in signed units of
// 2^-ANGLE_FRAC_BITS degree; roll and yaw within +-180, pitch within +-90.
// One result word per input word, in order.
// Throughput: one word per cycle when m_axis_tready stays high.
// Path: the front pipe (products, sums, radicand and a 29-stage square
// root), then the queue, then the CORDIC lanes (a half-plane turn, the
// micro-rotations and a rounding register).
// The front pipe and the CORDIC lanes each stall on their own; a 4-word
// queue sits between them. When m_axis_tready is low the back lanes hold,
// the queue fills, then the front pipe holds and s_axis_tready drops.
// Reset (rst, synchronous) empties all pipes and the queue; items in flight
// are dropped, and reset itself produces no item.
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // qw[15:0], qx[31:16], qy[47:32], qz[63:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
);

  q2e_vec_t f_data, b_data;
  logic     f_valid, f_ready, b_valid, b_ready;
  logic signed [ANG_W-1:0] roll, pitch, yaw;

  q2e_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .qw(s_axis_tdata[15:0]), .qx(s_axis_tdata[31:16]),
    .qy(s_axis_tdata[47:32]), .qz(s_axis_tdata[63:48]),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  q2e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  q2e_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .roll(roll), .pitch(pitch), .yaw(yaw)
  );

  // Pack the result word
  assign m_axis_tdata = {1'b0, yaw, pitch[PITCH_W-1:0], roll};

endmodule

>>> verif/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
  import q2e_pkg::*;

  localparam int STEPS     = DEF_CORDIC_STEPS;
  localparam int FRAC      = DEF_ANGLE_FRAC_BITS;
  localparam int LATENCY   = 53;
  localparam int STALL_MAX = 5000;
  localparam int N_RANDOM  = 1650;

  typedef struct packed {
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [15:0] qw;
  } quat_t;

  typedef struct packed {
    logic               pad;
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  int     mismatches = 0;
  int     phase = 0;          // 0: send idles 21%, recv 45%; 1: swapped; 2: none
  int     hold_off = 0;       // receiver long stall, cycles left
  bit     pause_send = 1'b0;  // sender starts no new words while set
  int     quiet_cycles = 0;

  quaternion_to_euler_angles dut (.*);

  always #5 clk = ~clk;

  // atan table in Q16 degrees
  function automatic longint atan_deg_q16(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // floor division by a power of two
  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((((-v) - 1) >>> s) + 1);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc = 0;
    longint t, dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        acc = 64'sd90 <<< 16; t = x; x = y; y = -t;
      end else begin
        acc = -(64'sd90 <<< 16); t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_deg_q16(i);
      end else begin
        x -= dx; y += dy; acc -= atan_deg_q16(i);
      end
    end
    return acc;
  endfunction

  // round half away from zero, then clamp
  function automatic longint round_degrees(longint q16, longint limit_deg);
    int     s = 16 - FRAC;
    longint lim = limit_deg <<< FRAC;
    longint mag = (q16 < 0) ? -q16 : q16;
    longint r = (mag + (64'sd1 <<< (s - 1))) >>> s;
    if (q16 < 0) r = -r;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w = q.qw, x = q.qx, y = q.qy, z = q.qz;
    longint one = 64'sd1 <<< 28;
    longint rn, rd, yn, yd, sn, cs;
    euler_t e;
    rn = 2 * (w * x + y * z);
    rd = one - 2 * (x * x + y * y);
    yn = 2 * (w * z + x * y);
    yd = one - 2 * (y * y + z * z);
    sn = 2 * (w * y - z * x);
    if (sn > one) sn = one;
    if (sn < -one) sn = -one;
    cs = int_sqrt(longint'(one * one - sn * sn));
    e.pad   = 1'b0;
    e.roll  = 16'(round_degrees(vector_angle(rn, rd), 180));
    e.pitch = 15'(round_degrees(vector_angle(sn, cs), 90));
    e.yaw   = 16'(round_degrees(vector_angle(yn, yd), 180));
    return e;
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.qw = 16'(w); q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z);
    return q;
  endfunction

  // random near-unit quaternion, some plain random words, some with random components in [-16384, 16383]
  function automatic quat_t random_quat();
    quat_t q;
    int r = $urandom_range(0, 9);
    if (r < 2) begin
      q = quat_t'({$urandom, $urandom});
    end else if (r < 4) begin
      q = make_quat($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                    $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
    end else begin
      real a, b, c, d, n;
      a = $urandom_range(0, 20000) - 10000.0; b = $urandom_range(0, 20000) - 10000.0;
      c = $urandom_range(0, 20000) - 10000.0; d = $urandom_range(0, 20000) - 10000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      q = make_quat(int'(a / n * 16384.0), int'(b / n * 16384.0),
                    int'(c / n * 16384.0), int'(d / n * 16384.0));
    end
    return q;
  endfunction

  // drive input words from the pending queue
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) pending_quats.pop_front();
      if ((s_axis_tvalid && !s_axis_tready) ||
          (pending_quats.size() != 0 && !pause_send &&
           !(phase == 0 && $urandom_range(0, 99) < 21) &&
           !(phase == 1 && $urandom_range(0, 99) < 45))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= (s_axis_tvalid && !s_axis_tready) ? s_axis_tdata :
                         pending_quats[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !((phase == 0 && $urandom_range(0, 99) < 45) ||
                         (phase == 1 && $urandom_range(0, 99) < 21));
    end
  end

  // record expected angles and compare result words
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_angles.push_back(predict_angles(quat_t'(s_axis_tdata)));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      euler_t got, want;
      got = euler_t'(m_axis_tdata);
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = expected_angles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d pad %b (exp/got)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
                     got.pad);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX + 10 * LATENCY) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_quats.size() != 0 || s_axis_tvalid || expected_angles.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int vals[6] = '{-32768, 32767, 0, 16384, -16384, 1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, axis turns, extremes, zero vector, saturated arcsine, edge-value mixes
    pending_quats.push_back(make_quat(16384, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 16384, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 16384, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 16384));
    pending_quats.push_back(make_quat(11585, 0, 11585, 0));
    pending_quats.push_back(make_quat(11585, 0, -11585, 0));
    pending_quats.push_back(make_quat(32767, 0, 32767, 0));
    pending_quats.push_back(make_quat(-32768, 0, 32767, 0));
    pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
    pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
    pending_quats.push_back(make_quat(0, 16384, 1, 0));
    pending_quats.push_back(make_quat(0, 16384, -1, 0));
    for (int i = 0; i < 11; i++)
      pending_quats.push_back(make_quat(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
                                        vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)]));
    wait_drained();

    // random, long receiver hold-off so the input stalls
    for (int i = 0; i < N_RANDOM / 3; i++) pending_quats.push_back(random_quat());
    hold_off = 400;
    wait_drained();

    // sender holds off while the batch is queued, then swapped idling
    pause_send = 1'b1;
    for (int i = 0; i < N_RANDOM / 3; i++) pending_quats.push_back(random_quat());
    repeat (3) @(posedge clk);
    pause_send = 1'b0;
    phase = 1;
    wait_drained();

    phase = 2;
    for (int i = 0; i < N_RANDOM - 2 * (N_RANDOM / 3); i++) pending_quats.push_back(random_quat());
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatches == 0 && expected_angles.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
